// ----- sv/mtkr_pkg.sv -----
// Shared types and constants for the top-k capacity router.
// Used by every module of the router; depends on nothing.
package mtkr_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int NUM_W       = 5;
    localparam int CAP_W       = 13;
    localparam int COUNT_W     = 5;
    localparam int MASK_W      = 16;
    localparam int TOTAL_W     = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_EXPERTS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOP_K       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY    = 2'd2;

    localparam logic [TOTAL_W-1:0] TOTAL_SAT = 17'd65536;

    typedef struct packed {
        logic fire;
        logic begin_batch;
        logic last_logit;
    } mtkr_step_t;

endpackage

// ----- sv/mtkr_topk_list.sv -----
// Running top-k selection of one token, kept as a rank and a list bit per expert.
// Depends on mtkr_pkg for the step control struct.
module mtkr_topk_list #(
    parameter int MAX_EXPERTS = 16,
    parameter int LOGIT_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mtkr_pkg::mtkr_step_t                  step,
    input  logic signed [LOGIT_BITS-1:0]          logit,
    input  logic [$clog2(MAX_EXPERTS+1)-1:0]      k_eff,
    input  logic [$clog2(MAX_EXPERTS+1)-1:0]      ne_eff,
    output logic                                  last,
    output logic [MAX_EXPERTS-1:0]                chosen
);

    localparam int RW = $clog2(MAX_EXPERTS);
    localparam int KW = $clog2(MAX_EXPERTS + 1);

    logic signed [LOGIT_BITS-1:0] score_reg [MAX_EXPERTS];
    logic [RW-1:0]                rank_reg  [MAX_EXPERTS];
    logic [MAX_EXPERTS-1:0]       alive_reg;
    logic [RW-1:0]                pos_reg;

    logic [MAX_EXPERTS-1:0] live;
    logic [MAX_EXPERTS-1:0] ge;
    logic [KW-1:0]          place;
    logic                   ins;
    logic [RW-1:0]          rank_next [MAX_EXPERTS];
    logic [MAX_EXPERTS-1:0] alive_next;
    logic [KW-1:0]          rank_up;

    always_comb
    begin
        place = '0;
        for (int j = 0; j < MAX_EXPERTS; j++)
        begin
            live[j] = (pos_reg != '0) && alive_reg[j];
            ge[j]   = live[j] && (KW'(rank_reg[j]) < k_eff) && (score_reg[j] >= logit);
            place   = place + KW'(ge[j]);
        end
        ins = place < k_eff;
    end

    always_comb
    begin
        for (int j = 0; j < MAX_EXPERTS; j++)
        begin
            rank_up       = KW'(rank_reg[j]) + KW'(1);
            rank_next[j]  = rank_reg[j];
            alive_next[j] = live[j];
            if (pos_reg == RW'(j))
            begin
                alive_next[j] = ins;
                rank_next[j]  = place[RW-1:0];
            end
            else if (ins && (KW'(rank_reg[j]) >= place))
            begin
                alive_next[j] = live[j] && (rank_up < k_eff);
                rank_next[j]  = rank_up[RW-1:0];
            end
            chosen[j] = alive_next[j] && (KW'(rank_next[j]) < k_eff);
        end
    end

    assign last = (KW'(pos_reg) + KW'(1)) >= ne_eff;

    always_ff @(posedge clk)
    begin
        if (step.fire && !step.begin_batch)
        begin
            score_reg[pos_reg] <= logit;
            for (int j = 0; j < MAX_EXPERTS; j++)
            begin
                rank_reg[j] <= rank_next[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= '0;
            pos_reg   <= '0;
        end
        else if (step.fire)
        begin
            if (step.begin_batch)
            begin
                pos_reg <= '0;
            end
            else
            begin
                alive_reg <= alive_next;
                pos_reg   <= last ? '0 : pos_reg + RW'(1);
            end
        end
    end

endmodule

// ----- sv/mtkr_load_check.sv -----
// Per-expert load counters, capacity check and saturating batch totals.
// Depends on mtkr_pkg for field widths, the saturation value and the step struct.
module mtkr_load_check #(
    parameter int MAX_EXPERTS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mtkr_pkg::mtkr_step_t                step,
    input  logic [MAX_EXPERTS-1:0]              chosen,
    input  logic [mtkr_pkg::CAP_W-1:0]          capacity,
    output logic [mtkr_pkg::MASK_W-1:0]         chosen_mask,
    output logic [mtkr_pkg::COUNT_W-1:0]        routed_count,
    output logic [mtkr_pkg::COUNT_W-1:0]        dropped_count,
    output logic [mtkr_pkg::TOTAL_W-1:0]        batch_routed,
    output logic [mtkr_pkg::TOTAL_W-1:0]        batch_dropped
);

    localparam int KW = $clog2(MAX_EXPERTS + 1);
    localparam int MW = (MAX_EXPERTS > mtkr_pkg::MASK_W) ? MAX_EXPERTS : mtkr_pkg::MASK_W;

    logic [mtkr_pkg::CAP_W-1:0]   load_reg [MAX_EXPERTS];
    logic [mtkr_pkg::TOTAL_W-1:0] routed_total_reg;
    logic [mtkr_pkg::TOTAL_W-1:0] dropped_total_reg;

    logic [MAX_EXPERTS-1:0]         kept;
    logic [MW-1:0]                  kept_wide;
    logic [KW-1:0]                  routed;
    logic [KW-1:0]                  dropped;
    logic [mtkr_pkg::TOTAL_W:0]     routed_sum;
    logic [mtkr_pkg::TOTAL_W:0]     dropped_sum;

    always_comb
    begin
        routed  = '0;
        dropped = '0;
        for (int e = 0; e < MAX_EXPERTS; e++)
        begin
            kept[e] = chosen[e] && (load_reg[e] < capacity);
            routed  = routed + KW'(kept[e]);
            dropped = dropped + KW'(chosen[e] && !kept[e]);
        end
    end

    assign kept_wide     = MW'(kept);
    assign chosen_mask   = kept_wide[mtkr_pkg::MASK_W-1:0];
    assign routed_count  = mtkr_pkg::COUNT_W'(routed);
    assign dropped_count = mtkr_pkg::COUNT_W'(dropped);

    assign routed_sum  = (mtkr_pkg::TOTAL_W+1)'(routed_total_reg) + (mtkr_pkg::TOTAL_W+1)'(routed);
    assign dropped_sum = (mtkr_pkg::TOTAL_W+1)'(dropped_total_reg)
                       + (mtkr_pkg::TOTAL_W+1)'(dropped);

    assign batch_routed  = (routed_sum > (mtkr_pkg::TOTAL_W+1)'(mtkr_pkg::TOTAL_SAT))
                         ? mtkr_pkg::TOTAL_SAT : routed_sum[mtkr_pkg::TOTAL_W-1:0];
    assign batch_dropped = (dropped_sum > (mtkr_pkg::TOTAL_W+1)'(mtkr_pkg::TOTAL_SAT))
                         ? mtkr_pkg::TOTAL_SAT : dropped_sum[mtkr_pkg::TOTAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < MAX_EXPERTS; e++)
            begin
                load_reg[e] <= '0;
            end
            routed_total_reg  <= '0;
            dropped_total_reg <= '0;
        end
        else if (step.fire)
        begin
            if (step.begin_batch)
            begin
                for (int e = 0; e < MAX_EXPERTS; e++)
                begin
                    load_reg[e] <= '0;
                end
                routed_total_reg  <= '0;
                dropped_total_reg <= '0;
            end
            else if (step.last_logit)
            begin
                for (int e = 0; e < MAX_EXPERTS; e++)
                begin
                    load_reg[e] <= load_reg[e] + mtkr_pkg::CAP_W'(kept[e]);
                end
                routed_total_reg  <= batch_routed;
                dropped_total_reg <= batch_dropped;
            end
        end
    end

endmodule

// ----- sv/moe_topk_capacity_router.sv -----
// A beat is held in the input register. A token's result is loaded into the output register as its
// last logit leaves that register. The router takes one beat per cycle, except while a token's last
// logit waits on a full, stalled output register; the rate is set by the rank update of the top-k list and the
// parallel load check. Reset clears loads, totals, the token in progress and both registers, and
// loads the configuration defaults of 16 experts, k of 2 and capacity 64.
module moe_topk_capacity_router #(
    parameter int MAX_EXPERTS = 16,
    parameter int LOGIT_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mtkr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mtkr_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  command,
    input  logic signed [LOGIT_BITS-1:0]          logit,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [mtkr_pkg::MASK_W-1:0]           chosen_mask,
    output logic [mtkr_pkg::COUNT_W-1:0]          routed_count,
    output logic [mtkr_pkg::COUNT_W-1:0]          dropped_count,
    output logic [mtkr_pkg::TOTAL_W-1:0]          batch_routed,
    output logic [mtkr_pkg::TOTAL_W-1:0]          batch_dropped
);

    localparam int KW = $clog2(MAX_EXPERTS + 1);

    logic [mtkr_pkg::NUM_W-1:0]     num_experts_reg;
    logic [mtkr_pkg::NUM_W-1:0]     top_k_reg;
    logic [mtkr_pkg::CAP_W-1:0]     capacity_reg;

    logic                           in_valid_reg;
    logic                           command_reg;
    logic signed [LOGIT_BITS-1:0]   logit_reg;

    logic                           out_valid_reg;
    logic [mtkr_pkg::MASK_W-1:0]    chosen_mask_reg;
    logic [mtkr_pkg::COUNT_W-1:0]   routed_count_reg;
    logic [mtkr_pkg::COUNT_W-1:0]   dropped_count_reg;
    logic [mtkr_pkg::TOTAL_W-1:0]   batch_routed_reg;
    logic [mtkr_pkg::TOTAL_W-1:0]   batch_dropped_reg;

    logic [KW-1:0]                  ne_eff;
    logic [KW-1:0]                  k_eff;
    logic                           last;
    logic                           produces;
    logic                           advance;
    logic [MAX_EXPERTS-1:0]         chosen;
    mtkr_pkg::mtkr_step_t           step;

    logic [mtkr_pkg::MASK_W-1:0]    mask_next;
    logic [mtkr_pkg::COUNT_W-1:0]   routed_next;
    logic [mtkr_pkg::COUNT_W-1:0]   dropped_next;
    logic [mtkr_pkg::TOTAL_W-1:0]   total_routed_next;
    logic [mtkr_pkg::TOTAL_W-1:0]   total_dropped_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_experts_reg <= mtkr_pkg::NUM_W'(16);
            top_k_reg       <= mtkr_pkg::NUM_W'(2);
            capacity_reg    <= mtkr_pkg::CAP_W'(64);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mtkr_pkg::CFG_NUM_EXPERTS: num_experts_reg <= cfg_data[mtkr_pkg::NUM_W-1:0];
                mtkr_pkg::CFG_TOP_K:       top_k_reg       <= cfg_data[mtkr_pkg::NUM_W-1:0];
                mtkr_pkg::CFG_CAPACITY:    capacity_reg    <= cfg_data[mtkr_pkg::CAP_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        priority if (num_experts_reg == '0)
        begin
            ne_eff = KW'(1);
        end
        else if (int'(num_experts_reg) > MAX_EXPERTS)
        begin
            ne_eff = KW'(MAX_EXPERTS);
        end
        else
        begin
            ne_eff = KW'(num_experts_reg);
        end

        priority if (top_k_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (int'(top_k_reg) > int'(ne_eff))
        begin
            k_eff = ne_eff;
        end
        else
        begin
            k_eff = KW'(top_k_reg);
        end
    end

    assign produces = !command_reg && last;
    assign advance  = in_valid_reg && (!produces || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            command_reg <= command;
            logit_reg   <= logit;
        end
    end

    assign step.fire        = advance;
    assign step.begin_batch = command_reg;
    assign step.last_logit  = last;

    mtkr_topk_list #(
        .MAX_EXPERTS (MAX_EXPERTS),
        .LOGIT_BITS  (LOGIT_BITS)
    ) u_topk_list (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .logit  (logit_reg),
        .k_eff  (k_eff),
        .ne_eff (ne_eff),
        .last   (last),
        .chosen (chosen)
    );

    mtkr_load_check #(
        .MAX_EXPERTS (MAX_EXPERTS)
    ) u_load_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .chosen        (chosen),
        .capacity      (capacity_reg),
        .chosen_mask   (mask_next),
        .routed_count  (routed_next),
        .dropped_count (dropped_next),
        .batch_routed  (total_routed_next),
        .batch_dropped (total_dropped_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && produces)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produces)
        begin
            chosen_mask_reg   <= mask_next;
            routed_count_reg  <= routed_next;
            dropped_count_reg <= dropped_next;
            batch_routed_reg  <= total_routed_next;
            batch_dropped_reg <= total_dropped_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign chosen_mask   = chosen_mask_reg;
    assign routed_count  = routed_count_reg;
    assign dropped_count = dropped_count_reg;
    assign batch_routed  = batch_routed_reg;
    assign batch_dropped = batch_dropped_reg;

endmodule

// ----- sv/mtkr_checker.sv -----
// Port-level checks on the router's result channel, bound to the top level.
// Depends on mtkr_pkg for field widths and the saturation value.
module mtkr_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [mtkr_pkg::MASK_W-1:0]     chosen_mask,
    input  logic [mtkr_pkg::COUNT_W-1:0]    routed_count,
    input  logic [mtkr_pkg::COUNT_W-1:0]    dropped_count,
    input  logic [mtkr_pkg::TOTAL_W-1:0]    batch_routed,
    input  logic [mtkr_pkg::TOTAL_W-1:0]    batch_dropped
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(chosen_mask) && $stable(batch_routed))
        else $error("Result beat changed while stalled.");

    a_mask_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(routed_count) == $countones(chosen_mask))
        else $error("Routed count disagrees with the chosen mask.");

    a_routed_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> batch_routed >= mtkr_pkg::TOTAL_W'(routed_count)
                   && batch_routed <= mtkr_pkg::TOTAL_SAT)
        else $error("Batch routed total is below this token's count or above saturation.");

    a_dropped_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> batch_dropped >= mtkr_pkg::TOTAL_W'(dropped_count)
                   && batch_dropped <= mtkr_pkg::TOTAL_SAT)
        else $error("Batch dropped total is below this token's count or above saturation.");

endmodule

bind moe_topk_capacity_router mtkr_checker u_mtkr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .chosen_mask   (chosen_mask),
    .routed_count  (routed_count),
    .dropped_count (dropped_count),
    .batch_routed  (batch_routed),
    .batch_dropped (batch_dropped)
);
